FILE: hw/rtl/i2cms_pkg.sv
`default_nettype none
package i2cms_pkg;

  localparam int BUFFER_BYTES = 16;
  localparam int IDX_W = $clog2(BUFFER_BYTES);
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(BUFFER_BYTES);

  // commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FETCH = 2'd2;

  // controller actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_NACK     = 3'd1;
  localparam logic [2:0] ACT_ACK      = 3'd2;
  localparam logic [2:0] ACT_STOP     = 3'd3;
  localparam logic [2:0] ACT_STOP_ACK = 3'd4;
  localparam logic [2:0] ACT_RESTART  = 3'd5;

  // outcomes
  localparam logic [1:0] OUT_RUNNING = 2'd0;
  localparam logic [1:0] OUT_DONE    = 2'd1;
  localparam logic [1:0] OUT_FAILED  = 2'd2;

  // bus status codes
  localparam logic [7:0] ST_BUS_ERR    = 8'h00;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
  localparam logic [7:0] ST_TXD_ACK    = 8'h28;
  localparam logic [7:0] ST_TXD_NACK   = 8'h30;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
  localparam logic [7:0] ST_RXD_ACK    = 8'h50;
  localparam logic [7:0] ST_RXD_NACK   = 8'h58;

  typedef struct packed {
    logic [1:0]       command;
    logic             interrupt_pending;
    logic [7:0]       bus_status;
    logic [6:0]       slave_address;
    logic [7:0]       received_byte;
    logic [7:0]       byte_to_send;
    logic [IDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic [2:0]       bus_action;
    logic             load_data;
    logic [7:0]       data_byte;
    logic [1:0]       outcome;
    logic [POS_W-1:0] receive_count;
    logic [POS_W-1:0] send_index;
    logic [7:0]       buffer_byte;
  } result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } flow_t;

endpackage
`default_nettype wire

FILE: hw/rtl/i2cms_in_stage.sv
`default_nettype none
module i2cms_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire i2cms_pkg::item_t in_item,
  input  wire logic          advance,
  output i2cms_pkg::flow_t   flow,
  output i2cms_pkg::item_t   item
);
  import i2cms_pkg::*;

  logic valid;

  assign in_ready     = !valid || advance;
  assign flow.valid   = valid;
  assign flow.advance = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/i2cms_engine.sv
`default_nettype none
module i2cms_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire i2cms_pkg::flow_t flow,
  input  wire i2cms_pkg::item_t item,
  output i2cms_pkg::result_t    result
);
  import i2cms_pkg::*;

  logic [POS_W-1:0] send_position;
  logic [POS_W-1:0] receive_position;
  logic [POS_W-1:0] send_position_next;
  logic [POS_W-1:0] receive_position_next;
  logic [7:0]       store [BUFFER_BYTES];
  logic             store_we;
  logic [POS_W-1:0] rx_bumped;
  logic             commit;

  assign commit    = flow.valid && flow.advance;
  assign rx_bumped = receive_position + POS_W'(1);

  always_comb begin
    result                = '0;
    send_position_next    = send_position;
    receive_position_next = receive_position;
    store_we              = 1'b0;
    case (item.command)
      CMD_READ: begin
        if (item.interrupt_pending) begin
          case (item.bus_status)
            ST_START, ST_RESTART: begin
              send_position_next    = '0;
              receive_position_next = '0;
              result.data_byte      = {item.slave_address, 1'b1};
              result.load_data      = 1'b1;
              result.bus_action     = ACT_NACK;
            end
            ST_TXD_ACK, ST_ARB_LOST: result.bus_action = ACT_RESTART;
            ST_SLAR_ACK: begin
              receive_position_next = POS_W'(1);
              result.bus_action     = ACT_ACK;
            end
            ST_SLAR_NACK: begin
              result.bus_action = ACT_STOP_ACK;
              result.outcome    = OUT_FAILED;
            end
            ST_RXD_ACK: begin
              // saturates at full; the byte is then dropped
              if (receive_position < POS_FULL) begin
                store_we = 1'b1;
                if (rx_bumped < POS_FULL) begin
                  receive_position_next = rx_bumped;
                  result.bus_action     = ACT_ACK;
                end else begin
                  receive_position_next = POS_FULL;
                  result.bus_action     = ACT_NACK;
                end
              end else begin
                receive_position_next = POS_FULL;
                result.bus_action     = ACT_NACK;
              end
            end
            ST_RXD_NACK: begin
              result.bus_action = ACT_STOP_ACK;
              result.outcome    = OUT_DONE;
            end
            ST_BUS_ERR: result.bus_action = ACT_STOP;
            default: ;
          endcase
        end
      end
      CMD_WRITE: begin
        if (item.interrupt_pending) begin
          case (item.bus_status)
            ST_START, ST_RESTART: begin
              send_position_next    = '0;
              receive_position_next = '0;
              result.data_byte      = {item.slave_address, 1'b0};
              result.load_data      = 1'b1;
              result.bus_action     = ACT_NACK;
            end
            ST_SLAW_ACK: begin
              result.data_byte   = item.byte_to_send;
              result.load_data   = 1'b1;
              send_position_next = POS_W'(1);
              result.bus_action  = ACT_NACK;
            end
            ST_SLAW_NACK, ST_TXD_NACK, ST_ARB_LOST: begin
              result.bus_action = ACT_STOP;
              result.outcome    = OUT_FAILED;
            end
            ST_TXD_ACK: begin
              if (send_position < POS_FULL) begin
                result.data_byte   = item.byte_to_send;
                result.load_data   = 1'b1;
                send_position_next = send_position + POS_W'(1);
                result.bus_action  = ACT_NACK;
              end else begin
                result.outcome     = OUT_DONE;
                send_position_next = '0;
                result.bus_action  = ACT_STOP;
              end
            end
            ST_SLAR_NACK, ST_BUS_ERR: result.bus_action = ACT_STOP;
            default: ;
          endcase
        end
      end
      CMD_FETCH: begin
        if ({1'b0, item.read_index} < (IDX_W+1)'(BUFFER_BYTES)) begin
          result.buffer_byte = store[item.read_index];
        end
      end
      default: ;
    endcase
    result.receive_count = receive_position_next;
    result.send_index    = send_position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_position    <= '0;
      receive_position <= '0;
    end else if (commit) begin
      send_position    <= send_position_next;
      receive_position <= receive_position_next;
    end
  end

  // the address acknowledge always lands its byte in entry 0
  always_ff @(posedge clk) begin
    if (commit && store_we) begin
      store[receive_position[IDX_W-1:0]] <= item.received_byte;
    end else if (commit && item.command == CMD_READ && item.interrupt_pending
                 && item.bus_status == ST_SLAR_ACK) begin
      store[0] <= item.received_byte;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/i2cms_out_stage.sv
`default_nettype none
module i2cms_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s1_valid,
  input  wire i2cms_pkg::result_t result,
  output logic                    advance,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output i2cms_pkg::result_t      out_word
);
  import i2cms_pkg::*;

  assign advance = s1_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/i2c_master_status_sequencer.sv
// Two-wire bus master status sequencer.
// Input channel (in_valid/in_ready) takes one word per bus status event or
// one receive buffer read (command 2). Output channel (out_valid/out_ready)
// returns one result word per input word, in order: controller action, byte
// to load, outcome, receive count, send index and the buffer byte.
// Path: an accepted word passes the input register, then the result
// register, and out_valid rises as it enters the result register.
// Throughput: one word per cycle while the receiver does not stall; the
// send and receive positions update as a word moves into the result
// register, so the next word sees them at once.
// Reset clears both positions and empties both registers; the receive
// buffer contents are not cleared and hold rubbish until written.
// When the receiver stalls, the result register holds its word, the input
// register keeps one more word, and in_ready then drops until out_ready.
`default_nettype none
module i2c_master_status_sequencer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] command,
  input  wire logic       interrupt_pending,
  input  wire logic [7:0] bus_status,
  input  wire logic [6:0] slave_address,
  input  wire logic [7:0] received_byte,
  input  wire logic [7:0] byte_to_send,
  input  wire logic [3:0] read_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      bus_action,
  output logic            load_data,
  output logic [7:0]      data_byte,
  output logic [1:0]      outcome,
  output logic [4:0]      receive_count,
  output logic [4:0]      send_index,
  output logic [7:0]      buffer_byte
);
  import i2cms_pkg::*;

  item_t   in_item;
  item_t   item;
  flow_t   flow;
  result_t result;
  result_t out_word;
  logic    advance;

  assign in_item.command           = command;
  assign in_item.interrupt_pending = interrupt_pending;
  assign in_item.bus_status        = bus_status;
  assign in_item.slave_address     = slave_address;
  assign in_item.received_byte     = received_byte;
  assign in_item.byte_to_send      = byte_to_send;
  assign in_item.read_index        = read_index[IDX_W-1:0];

  i2cms_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .flow     (flow),
    .item     (item)
  );

  i2cms_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .flow   (flow),
    .item   (item),
    .result (result)
  );

  i2cms_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (flow.valid),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign bus_action    = out_word.bus_action;
  assign load_data     = out_word.load_data;
  assign data_byte     = out_word.data_byte;
  assign outcome       = out_word.outcome;
  assign receive_count = out_word.receive_count;
  assign send_index    = out_word.send_index;
  assign buffer_byte   = out_word.buffer_byte;

endmodule
`default_nettype wire

FILE: hw/rtl/i2cms_checker.sv
`default_nettype none
module i2cms_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] bus_action,
  input wire logic       load_data,
  input wire logic [7:0] data_byte,
  input wire logic [1:0] outcome,
  input wire logic [4:0] receive_count,
  input wire logic [4:0] send_index
);
  import i2cms_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bus_action) && $stable(data_byte)
      && $stable(outcome) && $stable(receive_count) && $stable(send_index))
    else $error("stalled result word changed");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && !load_data |-> data_byte == 8'h00)
    else $error("data byte set without a load");

  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> receive_count <= POS_FULL && send_index <= POS_FULL)
    else $error("position beyond buffer size");

  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome != OUT_RUNNING |-> bus_action == ACT_STOP
      || bus_action == ACT_STOP_ACK)
    else $error("transfer ended without a stop");

endmodule

bind i2c_master_status_sequencer i2cms_checker u_i2cms_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .bus_action    (bus_action),
  .load_data     (load_data),
  .data_byte     (data_byte),
  .outcome       (outcome),
  .receive_count (receive_count),
  .send_index    (send_index)
);
`default_nettype wire
